// ===== sv/mep_pkg.sv =====
`timescale 1ns / 1ps

package mep_pkg;

	localparam int IMAGE_WIDTH  = 1024;
	localparam int IMAGE_HEIGHT = 1024;

	typedef logic signed [31:0] q_t;      // Q4.28
	typedef logic signed [33:0] opnd_t;   // multiplier operand, magnitude below 2^32
	typedef logic signed [36:0] prod_t;   // truncated Q28 product
	typedef logic [2:0]         cfg_index_t;

	typedef struct packed {
		logic [9:0] pixel_col;
		logic [9:0] pixel_row;
	} pixel_t;

	typedef struct packed {
		logic [9:0] iteration_count;
		logic       in_main_region;
	} result_t;

	localparam cfg_index_t REG_X_ORIGIN = 3'd0;
	localparam cfg_index_t REG_Y_ORIGIN = 3'd1;
	localparam cfg_index_t REG_X_STEP   = 3'd2;
	localparam cfg_index_t REG_Y_STEP   = 3'd3;
	localparam cfg_index_t REG_LIMIT    = 3'd4;

	localparam q_t         ORIGIN_RESET = -32'sd536870912;
	localparam q_t         STEP_RESET   = 32'sd1048576;
	localparam logic [9:0] LIMIT_RESET  = 10'd1023;

	localparam q_t                 Q_TWO      = 32'sd536870912;
	localparam q_t                 Q_NEG_TWO  = -32'sd536870912;
	localparam opnd_t              Q_ONE      = 34'sd268435456;
	localparam opnd_t              Q_QUARTER  = 34'sd67108864;
	localparam logic signed [37:0] Q_SIXTEENTH = 38'sd16777216;
	localparam logic signed [37:0] Q_FOUR     = 38'sd1073741824;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP,
		ST_SAT,
		ST_SC_MUL,
		ST_SC_SUM,
		ST_SC_MUL2,
		ST_SC_DEC,
		ST_IT_MUL,
		ST_IT_UPD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic map_mul;
		logic map_sat;
		logic sc_mul;
		logic sc_sum;
		logic sc_mul2;
		logic take_short;
		logic it_init;
		logic it_mul;
		logic it_upd;
	} cmd_t;

	typedef struct packed {
		logic shortcut;
		logic at_limit;
		logic escape;
	} stat_t;

	// Saturate a wide signed value to Q4.28.
	function automatic q_t sat_q(input logic signed [43:0] v);
		q_t r;
		if (&v[43:31] || ~|v[43:31]) begin
			r = q_t'(v[31:0]);
		end else if (v[43]) begin
			r = {1'b1, 31'd0};
		end else begin
			r = {1'b0, {31{1'b1}}};
		end
		return r;
	endfunction

endpackage

// ===== sv/mandelbrot_escape_time_pixel.sv =====
`timescale 1ns / 1ps

// Mandelbrot escape-time evaluator for one pixel at a time.
// Command channel: raise start with the pixel word (column, row); the word is
// taken at a clock edge where start is high and busy is low. busy stays high
// from the next cycle until the result has been shown.
// Result channel: done is high for exactly one cycle while result holds the
// iteration count and the cardioid/bulb flag. The receiver cannot stall; the
// word holds until the next pixel leaves its cardioid/bulb check. A new start
// is taken in the cycle after done. After the accept edge the controller
// maps the point (multiply, then add/saturate) and runs the cardioid/bulb
// check; a point inside goes straight to done. Otherwise each z = z*z + c
// step runs three parallel 32x32 multipliers, then add/saturate, until the
// count reaches the limit or z escapes.
// Configuration: cfg_valid/cfg_ready write channel, always ready; cfg_index
// 0..4 selects x_origin, y_origin, x_step, y_step, iteration_limit. Write only
// while idle. Other indexes are ignored.
// Reset (arst_n low, asynchronous): the controller goes idle and the registers
// take their defaults (origin -2.0, step 1/256, limit 1023).
module mandelbrot_escape_time_pixel (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mep_pkg::pixel_t     pixel,
	output logic                done,
	output mep_pkg::result_t    result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  mep_pkg::cfg_index_t cfg_index,
	input  logic [31:0]         cfg_data
);
	import mep_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Accept configuration words every cycle.
	assign cfg_ready = 1'b1;

	// Sequence map, shortcut test and the iteration loop.
	mep_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Hold registers, multipliers and the result word.
	mep_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule

// ===== sv/mep_qmul.sv =====
`timescale 1ns / 1ps

module mep_qmul (
	input  logic           clk,
	input  logic           en,
	input  mep_pkg::opnd_t a,
	input  mep_pkg::opnd_t b,
	output mep_pkg::prod_t p
);
	import mep_pkg::*;

	logic        neg;
	logic [33:0] abs_a;
	logic [33:0] abs_b;
	logic [63:0] mag;
	logic [35:0] trunc;
	prod_t       p_q;

	// Sign-magnitude product, truncated toward zero to 28 fraction bits.
	always_comb begin
		neg   = a[33] ^ b[33];
		abs_a = a[33] ? 34'(-a) : 34'(a);
		abs_b = b[33] ? 34'(-b) : 34'(b);
		mag   = 64'(abs_a[31:0]) * 64'(abs_b[31:0]);
		trunc = mag[63:28];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= neg ? -$signed({1'b0, trunc}) : $signed({1'b0, trunc});
		end
	end

	assign p = p_q;

endmodule

// ===== sv/mep_ctrl.sv =====
`timescale 1ns / 1ps

module mep_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  mep_pkg::stat_t stat,
	output mep_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);
	import mep_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (start) state_d = ST_MAP;
			ST_MAP:     state_d = ST_SAT;
			ST_SAT:     state_d = ST_SC_MUL;
			ST_SC_MUL:  state_d = ST_SC_SUM;
			ST_SC_SUM:  state_d = ST_SC_MUL2;
			ST_SC_MUL2: state_d = ST_SC_DEC;
			ST_SC_DEC:  state_d = stat.shortcut ? ST_DONE : ST_IT_MUL;
			ST_IT_MUL:  state_d = stat.at_limit ? ST_DONE : ST_IT_UPD;
			ST_IT_UPD:  state_d = stat.escape ? ST_DONE : ST_IT_MUL;
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_MAP:     cmd.map_mul = 1'b1;
			ST_SAT:     cmd.map_sat = 1'b1;
			ST_SC_MUL:  cmd.sc_mul  = 1'b1;
			ST_SC_SUM:  cmd.sc_sum  = 1'b1;
			ST_SC_MUL2: cmd.sc_mul2 = 1'b1;
			ST_SC_DEC: begin
				cmd.take_short = stat.shortcut;
				cmd.it_init    = !stat.shortcut;
			end
			ST_IT_MUL:  cmd.it_mul = !stat.at_limit;
			ST_IT_UPD:  cmd.it_upd = !stat.escape;
			ST_DONE:    done = 1'b1;
			default:    busy = 1'b1;
		endcase
	end

endmodule

// ===== sv/mep_datapath.sv =====
`timescale 1ns / 1ps

module mep_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  mep_pkg::cfg_index_t cfg_index,
	input  logic [31:0]         cfg_data,
	input  mep_pkg::pixel_t     pixel,
	input  mep_pkg::cmd_t       cmd,
	output mep_pkg::stat_t      stat,
	output mep_pkg::result_t    result
);
	import mep_pkg::*;

	q_t         x_origin_q;
	q_t         y_origin_q;
	q_t         x_step_q;
	q_t         y_step_q;
	logic [9:0] limit_q;

	logic [9:0]         col_q;
	logic [9:0]         row_q;
	logic [9:0]         col_c;
	logic [9:0]         row_c;
	logic signed [42:0] mapx_q;
	logic signed [42:0] mapy_q;
	q_t                 x0_q;
	q_t                 y0_q;
	q_t                 x_q;
	q_t                 y_q;
	opnd_t              q_q;
	opnd_t              qd_q;
	logic               bulb_q;
	logic [9:0]         count_q;
	logic               flag_q;

	opnd_t              dx_c;
	opnd_t              bx_c;
	opnd_t              q_c;
	logic               in_box;
	logic               cardioid;
	logic signed [37:0] esc_sum;

	opnd_t a0, b0, a1, b1, a2, b2;
	prod_t p0, p1, p2;
	logic  en0, en12;

	// Configuration registers; unknown indexes drop the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= ORIGIN_RESET;
			y_origin_q <= ORIGIN_RESET;
			x_step_q   <= STEP_RESET;
			y_step_q   <= STEP_RESET;
			limit_q    <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_ORIGIN: x_origin_q <= q_t'(cfg_data);
				REG_Y_ORIGIN: y_origin_q <= q_t'(cfg_data);
				REG_X_STEP:   x_step_q   <= q_t'(cfg_data);
				REG_Y_STEP:   y_step_q   <= q_t'(cfg_data);
				REG_LIMIT:    limit_q    <= cfg_data[9:0];
				default:      ;
			endcase
		end
	end

	// Clamp coordinates to the image.
	always_comb begin
		col_c = pixel.pixel_col;
		row_c = pixel.pixel_row;
		if ({3'd0, pixel.pixel_col} > 13'(IMAGE_WIDTH - 1)) begin
			col_c = 10'(IMAGE_WIDTH - 1);
		end
		if ({3'd0, pixel.pixel_row} > 13'(IMAGE_HEIGHT - 1)) begin
			row_c = 10'(IMAGE_HEIGHT - 1);
		end
	end

	always_comb begin
		dx_c     = 34'(x0_q) - Q_QUARTER;
		bx_c     = 34'(x0_q) + Q_ONE;
		q_c      = 34'(p0 + p1);
		in_box   = (x0_q < Q_TWO) && (x0_q > Q_NEG_TWO) &&
			(y0_q < Q_TWO) && (y0_q > Q_NEG_TWO);
		cardioid = p0 < (p1 >>> 2);
		esc_sum  = 38'(p0) + 38'(p1);
	end

	// Multiplier operand select: shortcut terms, then iteration terms.
	always_comb begin
		a0 = 34'(x_q);
		b0 = 34'(x_q);
		a1 = 34'(y_q);
		b1 = 34'(y_q);
		a2 = 34'(x_q);
		b2 = 34'(y_q);
		if (cmd.sc_mul) begin
			a0 = dx_c;
			b0 = dx_c;
			a1 = 34'(y0_q);
			b1 = 34'(y0_q);
			a2 = bx_c;
			b2 = bx_c;
		end else if (cmd.sc_mul2) begin
			a0 = q_q;
			b0 = qd_q;
		end
		en0  = cmd.sc_mul | cmd.sc_mul2 | cmd.it_mul;
		en12 = cmd.sc_mul | cmd.it_mul;
	end

	mep_qmul u_mul0 (.clk(clk), .en(en0),  .a(a0), .b(b0), .p(p0));
	mep_qmul u_mul1 (.clk(clk), .en(en12), .a(a1), .b(b1), .p(p1));
	mep_qmul u_mul2 (.clk(clk), .en(en12), .a(a2), .b(b2), .p(p2));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q <= col_c;
			row_q <= row_c;
		end
		if (cmd.map_mul) begin
			mapx_q <= 43'($signed({1'b0, col_q})) * 43'(x_step_q);
			mapy_q <= 43'($signed({1'b0, row_q})) * 43'(y_step_q);
		end
		if (cmd.map_sat) begin
			x0_q <= sat_q(44'(x_origin_q) + 44'(mapx_q));
			y0_q <= sat_q(44'(y_origin_q) + 44'(mapy_q));
		end
		if (cmd.sc_sum) begin
			q_q    <= q_c;
			qd_q   <= q_c + dx_c;
			bulb_q <= (38'(p2) + 38'(p1)) < Q_SIXTEENTH;
		end
		if (cmd.take_short) begin
			count_q <= limit_q;
			flag_q  <= 1'b1;
		end
		if (cmd.it_init) begin
			count_q <= '0;
			flag_q  <= 1'b0;
			x_q     <= '0;
			y_q     <= '0;
		end
		if (cmd.it_upd) begin
			x_q     <= sat_q(44'(p0) - 44'(p1) + 44'(x0_q));
			y_q     <= sat_q(44'(p2) + 44'(p2) + 44'(y0_q));
			count_q <= count_q + 10'd1;
		end
	end

	always_comb begin
		stat.shortcut = in_box && (cardioid || bulb_q);
		stat.at_limit = count_q >= limit_q;
		stat.escape   = esc_sum >= Q_FOUR;
		result.iteration_count = count_q;
		result.in_main_region  = flag_q;
	end

endmodule
